[design/tsp_pkg.sv]
// ----------------------------------------------------------------------------
// tsp_pkg
// shared types, constants and the quarter-wave sine table for the
// three-phase sine pwm datapath
// ----------------------------------------------------------------------------
package tsp_pkg;

	typedef logic [15:0] turn_t;
	typedef logic [14:0] mag_t;
	typedef logic [9:0]  amp_t;

	typedef struct packed {
		logic neg;
		mag_t mag;
	} sine_t;

	localparam amp_t         AMP_MAX         = 10'd1000;
	localparam logic [10:0]  FULL_SCALE      = 11'd1000;
	localparam turn_t        TURN_THIRD      = 16'd21845;
	localparam turn_t        TURN_TWO_THIRDS = 16'd43691;
	localparam mag_t         SINE_PEAK       = 15'd32767;
	localparam logic [14:0]  QUARTER_TURN    = 15'd16384;
	localparam logic [19:0]  INTERP_HALF     = 20'd256;

	// round(32767 * sin(i * pi / 64)), i = 0..32
	function automatic mag_t sine_entry(input logic [5:0] idx);
		mag_t v;
		case (idx)
			6'd0:  v = 15'd0;
			6'd1:  v = 15'd1608;
			6'd2:  v = 15'd3212;
			6'd3:  v = 15'd4808;
			6'd4:  v = 15'd6393;
			6'd5:  v = 15'd7962;
			6'd6:  v = 15'd9512;
			6'd7:  v = 15'd11039;
			6'd8:  v = 15'd12539;
			6'd9:  v = 15'd14010;
			6'd10: v = 15'd15446;
			6'd11: v = 15'd16846;
			6'd12: v = 15'd18204;
			6'd13: v = 15'd19519;
			6'd14: v = 15'd20787;
			6'd15: v = 15'd22005;
			6'd16: v = 15'd23170;
			6'd17: v = 15'd24279;
			6'd18: v = 15'd25329;
			6'd19: v = 15'd26319;
			6'd20: v = 15'd27245;
			6'd21: v = 15'd28105;
			6'd22: v = 15'd28898;
			6'd23: v = 15'd29621;
			6'd24: v = 15'd30273;
			6'd25: v = 15'd30852;
			6'd26: v = 15'd31356;
			6'd27: v = 15'd31785;
			6'd28: v = 15'd32137;
			6'd29: v = 15'd32412;
			6'd30: v = 15'd32609;
			6'd31: v = 15'd32728;
			6'd32: v = 15'd32767;
			default: v = 15'd32767;
		endcase
		return v;
	endfunction

endpackage

[design/tsp_sine.sv]
// ----------------------------------------------------------------------------
// tsp_sine
// two-stage sine magnitude: quadrant fold and table read, then linear
// interpolation; carries the sign of the half-wave alongside
// ----------------------------------------------------------------------------
module tsp_sine (
	input  logic               clk,
	input  tsp_pkg::turn_t     phase,
	output tsp_pkg::sine_t     sine
);

	logic [14:0]    folded;
	logic [5:0]     idx;
	tsp_pkg::mag_t  lo;
	tsp_pkg::mag_t  hi;
	logic [10:0]    diff;

	tsp_pkg::mag_t  lo_s2;
	logic [10:0]    diff_s2;
	logic [8:0]     fr_s2;
	logic           neg_s2;

	logic [19:0]    interp;

	always_comb begin
		if (phase[14]) begin
			folded = tsp_pkg::QUARTER_TURN - {1'b0, phase[13:0]};
		end else begin
			folded = {1'b0, phase[13:0]};
		end
		idx = folded[14:9];
		if (idx[5]) begin
			lo   = tsp_pkg::SINE_PEAK;
			hi   = tsp_pkg::SINE_PEAK;
		end else begin
			lo   = tsp_pkg::sine_entry(idx);
			hi   = tsp_pkg::sine_entry(idx + 6'd1);
		end
		diff = 11'(hi - lo);
	end

	always_ff @(posedge clk) begin
		lo_s2   <= lo;
		diff_s2 <= diff;
		fr_s2   <= folded[8:0];
		neg_s2  <= phase[15];
	end

	assign interp = 20'(diff_s2) * 20'(fr_s2) + tsp_pkg::INTERP_HALF;

	always_ff @(posedge clk) begin
		sine.neg <= neg_s2;
		sine.mag <= lo_s2 + 15'(interp >> 9);
	end

endmodule

[design/tsp_duty.sv]
// ----------------------------------------------------------------------------
// tsp_duty
// three-stage duty scaling: amplitude product and offset, pulse-max
// product, then exact division by full scale through a reciprocal
// ----------------------------------------------------------------------------
module tsp_duty #(
	parameter int PULSE_BITS = 16
) (
	input  logic                   clk,
	input  tsp_pkg::amp_t          amp,
	input  tsp_pkg::sine_t         sine,
	input  logic [PULSE_BITS-1:0]  pulse_max,
	output logic [PULSE_BITS-1:0]  width
);

	localparam int PROD_W    = 10 + PULSE_BITS;
	localparam int DIV_SHIFT = PROD_W + 10;
	localparam int RECIP_W   = DIV_SHIFT - 9;
	localparam int WIDE_W    = PROD_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << DIV_SHIFT)
		+ 64'(tsp_pkg::FULL_SCALE) - 64'd1) / 64'(tsp_pkg::FULL_SCALE));

	logic [24:0]        amp_prod;
	logic [10:0]        base;
	logic [9:0]         half_s4;
	logic [PROD_W-1:0]  prod_s5;
	logic [WIDE_W-1:0]  scaled;

	always_comb begin
		amp_prod = 25'(amp) * 25'(sine.mag);
		if (sine.neg) begin
			base = tsp_pkg::FULL_SCALE - 11'(amp_prod[24:15]);
		end else begin
			base = tsp_pkg::FULL_SCALE + 11'(amp_prod[24:15]);
		end
	end

	always_ff @(posedge clk) begin
		half_s4 <= base[10:1];
	end

	always_ff @(posedge clk) begin
		prod_s5 <= PROD_W'(half_s4) * PROD_W'(pulse_max);
	end

	assign scaled = WIDE_W'(prod_s5) * WIDE_W'(RECIP);

	always_ff @(posedge clk) begin
		width <= PULSE_BITS'(scaled >> DIV_SHIFT);
	end

endmodule

[design/three_phase_sine_pwm.sv]
// ----------------------------------------------------------------------------
// three_phase_sine_pwm
// turns an amplitude/angle voltage vector into three pwm compare values for
// phases spaced a third of a turn apart
// ----------------------------------------------------------------------------
//  channel  | ports                                      | handshake
//  ---------+--------------------------------------------+----------------------
//  input    | amplitude, angle                           | start & !busy
//  result   | width_a, width_b, width_c                  | done, one cycle
//  config   | pulse_max                                  | pulse_max_we
//
//  one transaction enters per cycle and passes through six register stages:
//  input, table read, interpolation, amplitude product, pulse product,
//  reciprocal divide
//  busy stays low; the result side cannot stall, so the pipeline never holds
//  reset clears the valid bits and sets pulse_max to 1000
// ----------------------------------------------------------------------------
module three_phase_sine_pwm #(
	parameter int ANGLE_BITS = 12,
	parameter int PULSE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [9:0]             amplitude,
	input  logic [ANGLE_BITS-1:0]  angle,
	input  logic                   pulse_max_we,
	input  logic [PULSE_BITS-1:0]  pulse_max,
	output logic                   done,
	output logic [PULSE_BITS-1:0]  width_a,
	output logic [PULSE_BITS-1:0]  width_b,
	output logic [PULSE_BITS-1:0]  width_c
);

	logic [PULSE_BITS-1:0]  pulse_max_q;
	logic                   valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	tsp_pkg::turn_t         turn;
	tsp_pkg::amp_t          amp_s1, amp_s2, amp_s3;
	tsp_pkg::turn_t         phase_s1 [3];
	tsp_pkg::sine_t         sine_s3 [3];
	logic [PULSE_BITS-1:0]  width_s6 [3];

	assign busy = 1'b0;
	assign turn = tsp_pkg::turn_t'(angle) << (16 - ANGLE_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_max_q <= PULSE_BITS'(tsp_pkg::FULL_SCALE);
		end else if (pulse_max_we) begin
			pulse_max_q <= pulse_max;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// amplitude saturates at full scale
	always_ff @(posedge clk) begin
		amp_s1      <= (amplitude > tsp_pkg::AMP_MAX) ? tsp_pkg::AMP_MAX : amplitude;
		phase_s1[0] <= turn;
		phase_s1[1] <= turn + tsp_pkg::TURN_THIRD;
		phase_s1[2] <= turn + tsp_pkg::TURN_TWO_THIRDS;
		amp_s2      <= amp_s1;
		amp_s3      <= amp_s2;
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		tsp_sine u_sine (
			.clk   (clk),
			.phase (phase_s1[g]),
			.sine  (sine_s3[g])
		);

		tsp_duty #(
			.PULSE_BITS (PULSE_BITS)
		) u_duty (
			.clk       (clk),
			.amp       (amp_s3),
			.sine      (sine_s3[g]),
			.pulse_max (pulse_max_q),
			.width     (width_s6[g])
		);
	end

	assign done    = valid_s6;
	assign width_a = width_s6[0];
	assign width_b = width_s6[1];
	assign width_c = width_s6[2];

endmodule
